// ----- rtl/core/indexed_min_heap_decrease_key_top_defines.svh -----
// Assertion macros used by the heap datapath
`ifndef INDEXED_MIN_HEAP_DECREASE_KEY_TOP_DEFINES_SVH
`define INDEXED_MIN_HEAP_DECREASE_KEY_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define IMHDK_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define IMHDK_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/imhdk_pkg.sv -----
// Types and constants shared by the indexed min-heap modules
package imhdk_pkg;

    localparam int CMD_W       = 2;
    localparam int NODE_W      = 10;
    localparam int KEY_W       = 31;
    localparam int SIZE_W      = 11;
    localparam int NODE_SPAN   = 1 << NODE_W;
    localparam int IN_TDATA_W  = ((NODE_W + KEY_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((NODE_W + KEY_W + SIZE_W + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_UPSERT = 2'd1,
        CMD_POP    = 2'd2
    } cmd_t;

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_CLR,
        S_INS_POS,
        S_INS_SLOT,
        S_INS_CHK,
        S_UP_RD,
        S_UP_CMP,
        S_PLACE,
        S_POP_ROOT,
        S_POP_LAST,
        S_POP_GET,
        S_DN_RD,
        S_DN_FIRST,
        S_DN_SEL,
        S_DN_CMP,
        S_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic take;
        logic clr_start;
        logic clr_step;
        logic clr_all;
        logic ins_rd_slot;
        logic ins_chk;
        logic up_rd;
        logic up_move;
        logic place;
        logic pop_rd_root;
        logic pop_rd_last;
        logic pop_last;
        logic pop_empty;
        logic dn_rd;
        logic dn_first;
        logic dn_sel;
        logic dn_move;
        logic load_out;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic node_ok;
        logic clr_more;
        logic heap_empty;
        logic up_more;
        logic up_swap;
        logic dn_left;
        logic dn_right;
        logic dn_swap;
        logic out_free;
    } dp_sts_t;

endpackage

// ----- rtl/core/imhdk_ram.sv -----
// Simple dual-port RAM: one write port, one read port with registered data
module imhdk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/imhdk_dp.sv -----
// Heap datapath: slot and position stores, sift registers, result register
`include "indexed_min_heap_decrease_key_top_defines.svh"

module imhdk_dp #(
    parameter int DEPTH = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wen,
    input  logic [imhdk_pkg::SIZE_W-1:0]  cfg_wdata,
    input  logic [imhdk_pkg::NODE_W-1:0]  in_node,
    input  logic [imhdk_pkg::KEY_W-1:0]   in_key,
    input  imhdk_pkg::dp_cmd_t            cmd,
    output imhdk_pkg::dp_sts_t            sts,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [imhdk_pkg::NODE_W-1:0]  out_node,
    output logic [imhdk_pkg::KEY_W-1:0]   out_key,
    output logic                          empty_res,
    output logic [imhdk_pkg::SIZE_W-1:0]  size
);

    import imhdk_pkg::*;

    localparam int NAW = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int EW  = KEY_W + NAW;
    localparam int XW  = SIZE_W + 1;

    // Control state
    logic [CW-1:0]     count_reg;
    logic [SIZE_W-1:0] node_count_reg;
    logic [CW-1:0]     clr_reg;
    logic              out_valid_reg;

    // Item and sift state
    logic [NAW-1:0]    item_node_reg;
    logic [KEY_W-1:0]  item_key_reg;
    logic [CW-1:0]     hole_reg;
    logic [EW-1:0]     ent_reg;
    logic [EW-1:0]     chl_reg;
    logic [CW-1:0]     chs_reg;
    logic [NAW-1:0]    res_node_reg;
    logic [KEY_W-1:0]  res_key_reg;
    logic              res_empty_reg;
    logic [NODE_W-1:0] out_node_reg;
    logic [KEY_W-1:0]  out_key_reg;
    logic              out_empty_reg;
    logic [SIZE_W-1:0] out_size_reg;

    // Memory ports; an entry is {key, node} so one compare orders it
    logic           sl_we;
    logic [NAW-1:0] sl_waddr;
    logic [EW-1:0]  sl_wdata;
    logic [NAW-1:0] sl_raddr;
    logic [EW-1:0]  sl_rdata;
    logic           ps_we;
    logic [NAW-1:0] ps_waddr;
    logic [CW-1:0]  ps_wdata;
    logic [CW-1:0]  ps_rdata;

    logic [CW-1:0]  hole_m1;
    logic [CW-1:0]  par_m1;
    logic [CW-1:0]  cnt_m1;
    logic [CW-1:0]  pos_m1;
    logic [CW:0]    c_even;
    logic [CW:0]    c_odd;
    logic [CW:0]    c_m1;
    logic [CW:0]    cnt_ext;
    logic [XW-1:0]  dep_ext;
    logic [XW-1:0]  clr_ext;
    logic [XW-1:0]  clr_lim;
    logic           present;

    always_comb
    begin
        hole_m1 = hole_reg - CW'(1);
        par_m1  = (hole_reg >> 1) - CW'(1);
        cnt_m1  = count_reg - CW'(1);
        pos_m1  = ps_rdata - CW'(1);
        c_even  = {hole_reg, 1'b0};
        c_odd   = {hole_reg, 1'b1};
        c_m1    = c_even - (CW + 1)'(1);
        cnt_ext = {1'b0, count_reg};
        dep_ext = XW'(DEPTH);
        clr_ext = XW'(clr_reg);
        clr_lim = (XW'(node_count_reg) > dep_ext) ? dep_ext : XW'(node_count_reg);
        // Present only if the recorded slot is live and points back at the node
        present = (hole_reg != '0) && (hole_reg <= count_reg)
                  && (sl_rdata[NAW-1:0] == item_node_reg);
    end

    always_comb
    begin
        sl_raddr = c_even[NAW-1:0];
        if (cmd.ins_rd_slot)
        begin
            sl_raddr = pos_m1[NAW-1:0];
        end
        else if (cmd.up_rd)
        begin
            sl_raddr = par_m1[NAW-1:0];
        end
        else if (cmd.pop_rd_root)
        begin
            sl_raddr = '0;
        end
        else if (cmd.pop_rd_last)
        begin
            sl_raddr = cnt_m1[NAW-1:0];
        end
        else if (cmd.dn_rd)
        begin
            sl_raddr = c_m1[NAW-1:0];
        end

        sl_we    = cmd.up_move | cmd.place | cmd.dn_move;
        sl_waddr = hole_m1[NAW-1:0];
        if (cmd.up_move)
        begin
            sl_wdata = sl_rdata;
        end
        else if (cmd.dn_move)
        begin
            sl_wdata = chl_reg;
        end
        else
        begin
            sl_wdata = ent_reg;
        end

        ps_we    = cmd.clr_step | cmd.up_move | cmd.place | cmd.dn_move;
        ps_wdata = cmd.clr_step ? '0 : hole_reg;
        if (cmd.clr_step)
        begin
            ps_waddr = clr_reg[NAW-1:0];
        end
        else if (cmd.up_move)
        begin
            ps_waddr = sl_rdata[NAW-1:0];
        end
        else if (cmd.dn_move)
        begin
            ps_waddr = chl_reg[NAW-1:0];
        end
        else
        begin
            ps_waddr = ent_reg[NAW-1:0];
        end
    end

    always_comb
    begin
        sts.node_ok    = XW'(in_node) < dep_ext;
        sts.clr_more   = clr_ext < (cmd.clr_all ? dep_ext : clr_lim);
        sts.heap_empty = (count_reg == '0);
        sts.up_more    = hole_reg > CW'(1);
        sts.up_swap    = ent_reg < sl_rdata;
        sts.dn_left    = c_even <= cnt_ext;
        sts.dn_right   = c_odd <= cnt_ext;
        sts.dn_swap    = chl_reg < ent_reg;
        sts.out_free   = !out_valid_reg || out_ready;
    end

    imhdk_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_slot_ram (
        .clk   (clk),
        .we    (sl_we),
        .waddr (sl_waddr),
        .wdata (sl_wdata),
        .raddr (sl_raddr),
        .rdata (sl_rdata)
    );

    imhdk_ram #(
        .WIDTH (CW),
        .DEPTH (DEPTH)
    ) u_pos_ram (
        .clk   (clk),
        .we    (ps_we),
        .waddr (ps_waddr),
        .wdata (ps_wdata),
        .raddr (item_node_reg),
        .rdata (ps_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            node_count_reg <= SIZE_W'(NODE_SPAN);
            clr_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                node_count_reg <= cfg_wdata;
            end
            if (cmd.clr_start)
            begin
                count_reg <= '0;
                clr_reg   <= '0;
            end
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + CW'(1);
            end
            if (cmd.ins_chk && !present)
            begin
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.pop_rd_last)
            begin
                count_reg <= cnt_m1;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            item_node_reg <= in_node[NAW-1:0];
            item_key_reg  <= in_key;
            res_node_reg  <= '0;
            res_key_reg   <= '0;
            res_empty_reg <= cmd.pop_empty;
        end
        if (cmd.ins_rd_slot)
        begin
            hole_reg <= ps_rdata;
        end
        if (cmd.ins_chk)
        begin
            ent_reg <= {item_key_reg, item_node_reg};
            if (!present)
            begin
                hole_reg <= count_reg + CW'(1);
            end
        end
        if (cmd.up_move)
        begin
            hole_reg <= hole_reg >> 1;
        end
        if (cmd.pop_rd_last)
        begin
            res_node_reg <= sl_rdata[NAW-1:0];
            res_key_reg  <= sl_rdata[EW-1:NAW];
        end
        if (cmd.pop_last)
        begin
            ent_reg  <= sl_rdata;
            hole_reg <= CW'(1);
        end
        if (cmd.dn_first)
        begin
            chl_reg <= sl_rdata;
            chs_reg <= c_even[CW-1:0];
        end
        // Take the right child when it orders ahead of the left
        if (cmd.dn_sel && (sl_rdata < chl_reg))
        begin
            chl_reg <= sl_rdata;
            chs_reg <= c_odd[CW-1:0];
        end
        if (cmd.dn_move)
        begin
            hole_reg <= chs_reg;
        end
        if (cmd.load_out)
        begin
            out_node_reg  <= NODE_W'(res_node_reg);
            out_key_reg   <= res_key_reg;
            out_empty_reg <= res_empty_reg;
            out_size_reg  <= SIZE_W'(count_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_node  = out_node_reg;
    assign out_key   = out_key_reg;
    assign empty_res = out_empty_reg;
    assign size      = out_size_reg;

    `IMHDK_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(DEPTH),
        "heap count exceeds store depth")
    `IMHDK_ASSERT_NOW(a_place_live, cmd.place,
        (hole_reg != '0) && (hole_reg <= count_reg), "placing outside live slots")
    `IMHDK_ASSERT_NEXT(a_sift_down_descends, cmd.dn_move, hole_reg > $past(hole_reg),
        "sift-down did not move deeper")
    `IMHDK_ASSERT_NOW(a_load_when_free, cmd.load_out, !out_valid_reg || out_ready,
        "result register overwritten while full")

endmodule

// ----- rtl/core/imhdk_ctrl.sv -----
// Heap controller: sequences clear, insert/decrease sift-up and pop sift-down
module imhdk_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [imhdk_pkg::CMD_W-1:0]  in_command,
    output logic                         in_ready,
    input  imhdk_pkg::dp_sts_t           sts,
    output imhdk_pkg::dp_cmd_t           cmd
);

    import imhdk_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_INIT:
            begin
                // Zero the whole position store once after reset
                cmd.clr_all = 1'b1;
                if (sts.clr_more)
                begin
                    cmd.clr_step = 1'b1;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    case (cmd_t'(in_command))
                        CMD_CLEAR:
                        begin
                            cmd.clr_start = 1'b1;
                            state_next    = S_CLR;
                        end
                        CMD_UPSERT:
                        begin
                            state_next = sts.node_ok ? S_INS_POS : S_DONE;
                        end
                        CMD_POP:
                        begin
                            if (sts.heap_empty)
                            begin
                                cmd.pop_empty = 1'b1;
                                state_next    = S_DONE;
                            end
                            else
                            begin
                                state_next = S_POP_ROOT;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_CLR:
            begin
                if (sts.clr_more)
                begin
                    cmd.clr_step = 1'b1;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_INS_POS:
            begin
                state_next = S_INS_SLOT;
            end
            S_INS_SLOT:
            begin
                cmd.ins_rd_slot = 1'b1;
                state_next      = S_INS_CHK;
            end
            S_INS_CHK:
            begin
                cmd.ins_chk = 1'b1;
                state_next  = S_UP_RD;
            end
            S_UP_RD:
            begin
                if (sts.up_more)
                begin
                    cmd.up_rd  = 1'b1;
                    state_next = S_UP_CMP;
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end
            S_UP_CMP:
            begin
                if (sts.up_swap)
                begin
                    cmd.up_move = 1'b1;
                    state_next  = S_UP_RD;
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE:
            begin
                cmd.place  = 1'b1;
                state_next = S_DONE;
            end
            S_POP_ROOT:
            begin
                cmd.pop_rd_root = 1'b1;
                state_next      = S_POP_LAST;
            end
            S_POP_LAST:
            begin
                cmd.pop_rd_last = 1'b1;
                state_next      = S_POP_GET;
            end
            S_POP_GET:
            begin
                // Count is already decremented; drop the sift if nothing is left
                cmd.pop_last = 1'b1;
                state_next   = sts.heap_empty ? S_DONE : S_DN_RD;
            end
            S_DN_RD:
            begin
                if (sts.dn_left)
                begin
                    cmd.dn_rd  = 1'b1;
                    state_next = S_DN_FIRST;
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end
            S_DN_FIRST:
            begin
                cmd.dn_first = 1'b1;
                state_next   = sts.dn_right ? S_DN_SEL : S_DN_CMP;
            end
            S_DN_SEL:
            begin
                cmd.dn_sel = 1'b1;
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                if (sts.dn_swap)
                begin
                    cmd.dn_move = 1'b1;
                    state_next  = S_DN_RD;
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/indexed_min_heap_decrease_key_top.sv -----
// Indexed binary min-heap with insert-or-decrease-key, pop-min and clear.
// Each command beat returns one result beat. After reset the block zeroes its
// position store, one entry per cycle (min(MAX_HEAP_NODES, 1024) entries, 1024
// at the default), before it raises s_axis_tready. Commands run one at a time
// and their length is set by the slot memory, which has one read port with a
// registered output: insert or decrease climbs the node level by level, pop
// sinks the last entry level by level, reading the children of each level
// before it compares, and clear zeroes the first min(node_count, depth)
// position entries. A finished result waits in an output register, so the
// next command is taken while it is still unread.
module indexed_min_heap_decrease_key_top #(
    parameter int MAX_HEAP_NODES = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wen,
    input  logic [imhdk_pkg::SIZE_W-1:0]      cfg_wdata,     // node_count
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [imhdk_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // node[9:0], key[40:10]
    input  logic [imhdk_pkg::CMD_W-1:0]       s_axis_tuser,  // command[1:0]
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [imhdk_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // out_node[9:0],
                                                             // out_key[40:10], size[51:41]
    output logic                              m_axis_tuser   // empty_res
);

    import imhdk_pkg::*;

    localparam int DEPTH = (MAX_HEAP_NODES < NODE_SPAN) ? MAX_HEAP_NODES : NODE_SPAN;

    dp_cmd_t           cmd;
    dp_sts_t           sts;
    logic [NODE_W-1:0] out_node;
    logic [KEY_W-1:0]  out_key;
    logic [SIZE_W-1:0] size;

    imhdk_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_command (s_axis_tuser),
        .in_ready   (s_axis_tready),
        .sts        (sts),
        .cmd        (cmd)
    );

    imhdk_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .in_node   (s_axis_tdata[NODE_W-1:0]),
        .in_key    (s_axis_tdata[NODE_W +: KEY_W]),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_node  (out_node),
        .out_key   (out_key),
        .empty_res (m_axis_tuser),
        .size      (size)
    );

    assign m_axis_tdata = OUT_TDATA_W'({size, out_key, out_node});

endmodule
